// ===== sv/assert_macros.svh =====
// assertion helpers included by qaar_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication checked on the next edge
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/qaar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaar_pkg
// shared types and constants of the quaternion axis-angle rotator
// ----------------------------------------------------------------------------
package qaar_pkg;

  localparam int AXIS_W  = 16;
  localparam int ANGLE_W = 16;
  localparam int TRIG_W  = 16;  // signed Q14 sine and cosine, -16384..16384

  localparam logic [30:0] KC1 = 31'd1686629713;
  localparam logic [30:0] KC3 = 31'd693598668;
  localparam logic [30:0] KC5 = 31'd85569306;
  localparam logic [30:0] KC7 = 31'd5026995;
  localparam logic [30:0] KC9 = 31'd172273;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  // classified front result: half angle split into two kernel arguments
  typedef struct packed {
    logic [15:0] ts;   // sine kernel argument, Q15 0..32768
    logic [15:0] tc;   // cosine kernel argument
    logic        cneg; // cosine is negated
  } trig_arg_t;

endpackage

// ===== sv/qaar_sine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaar_sine
// pipelined sin(pi/2 t) kernel, Horner polynomial, Q15 in, Q14 out
// ----------------------------------------------------------------------------
module qaar_sine (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] t_i,
  output logic [14:0] s_o
);

  // stage registers, one multiply per stage
  logic [30:0] x_q [0:5];
  logic [30:0] x2_q [1:4];
  logic [30:0] p_q [2:5];
  logic [61:0] m0;
  logic [61:0] m1, m2, m3, m4, m5;
  logic [30:0] pf;
  logic [14:0] s_q;

  assign m0 = 62'(x_q[0]) * 62'(x_q[0]);
  assign m1 = 62'(qaar_pkg::KC9) * 62'(x2_q[1]);
  assign m2 = 62'(p_q[2]) * 62'(x2_q[2]);
  assign m3 = 62'(p_q[3]) * 62'(x2_q[3]);
  assign m4 = 62'(p_q[4]) * 62'(x2_q[4]);
  assign m5 = 62'(p_q[5]) * 62'(x_q[5]);

  always_comb begin
    pf = m5[60:30];
    if (pf > qaar_pkg::ONE_Q30) pf = qaar_pkg::ONE_Q30;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= {t_i, 15'd0};
      x_q[1]  <= x_q[0];
      x2_q[1] <= m0[60:30];
      x_q[2]  <= x_q[1]; x2_q[2] <= x2_q[1];
      p_q[2]  <= qaar_pkg::KC7 - m1[60:30];
      x_q[3]  <= x_q[2]; x2_q[3] <= x2_q[2];
      p_q[3]  <= qaar_pkg::KC5 - m2[60:30];
      x_q[4]  <= x_q[3]; x2_q[4] <= x2_q[3];
      p_q[4]  <= qaar_pkg::KC3 - m3[60:30];
      x_q[5]  <= x_q[4];
      p_q[5]  <= qaar_pkg::KC1 - m4[60:30];
      s_q     <= 15'((32'(pf) + 32'd32768) >> 16);
    end
  end

  assign s_o = s_q;

endmodule

// ===== sv/qaar_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaar_front
// input stage: registers items and classifies the half angle quadrant
// ----------------------------------------------------------------------------
module qaar_front #(
  parameter int CoordW = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic signed [CoordW-1:0]   px_i, py_i, pz_i,
  input  logic signed [15:0]         ax_i, ay_i, az_i,
  input  logic [15:0]                angle_i,
  output logic                       vld_o,
  input  logic                       rdy_i,
  output logic [3*CoordW+48-1:0]     data_o,
  output qaar_pkg::trig_arg_t        arg_o
);

  logic vld_q;
  logic [3*CoordW+48-1:0] data_q;
  qaar_pkg::trig_arg_t arg_q, arg_d;

  always_comb begin
    if (!angle_i[15]) begin
      arg_d.ts = {1'b0, angle_i[14:0]};
      arg_d.tc = 16'd32768 - {1'b0, angle_i[14:0]};
      arg_d.cneg = 1'b0;
    end else begin
      arg_d.ts = 16'd32768 - {1'b0, angle_i[14:0]};
      arg_d.tc = {1'b0, angle_i[14:0]};
      arg_d.cneg = 1'b1;
    end
  end

  assign full_o = vld_q && !rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (!full_o) vld_q <= push_i;
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      data_q <= {px_i, py_i, pz_i, ax_i, ay_i, az_i};
      arg_q  <= arg_d;
    end
  end

  assign vld_o = vld_q;
  assign data_o = data_q;
  assign arg_o = arg_q;

endmodule

// ===== sv/qaar_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaar_back
// rotation pipeline with credit-based result queue
// ----------------------------------------------------------------------------
module qaar_back #(
  parameter int CoordW = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  output logic                     rdy_o,
  input  logic [3*CoordW+48-1:0]   data_i,
  input  qaar_pkg::trig_arg_t      arg_i,
  output logic                     empty_o,
  input  logic                     pop_i,
  output logic signed [CoordW-1:0] rx_o, ry_o, rz_o,
  output logic                     sat_o
);
`include "assert_macros.svh"

  localparam int LAT = 11;          // register stages before the queue write
  localparam int QD  = 16;          // result queue depth, > LAT
  localparam int QA  = $clog2(QD);
  localparam int R1W = CoordW + 19; // Q30 partial products
  localparam int R2W = R1W + 19;

  // ---- pipeline stall-free: advance always, credit limited ----
  logic [LAT-1:0] v_q;
  logic [QA:0] cnt_q;   // queue entries plus items in flight
  logic take, deq;

  assign deq  = pop_i && !empty_o;
  assign rdy_o = (cnt_q < (QA+1)'(QD));
  assign take = vld_i && rdy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0; cnt_q <= '0;
    end else begin
      v_q <= {v_q[LAT-2:0], take};
      cnt_q <= cnt_q + (QA+1)'(take) - (QA+1)'(deq);
    end
  end

  // ---- trig, stages 1..7 ----
  logic [14:0] s_k, c_k;
  qaar_sine u_sin (.clk_i, .en_i(1'b1), .t_i(arg_i.ts), .s_o(s_k));
  qaar_sine u_cos (.clk_i, .en_i(1'b1), .t_i(arg_i.tc), .s_o(c_k));

  logic [3*CoordW+48-1:0] dl_q [0:6];
  logic cn_q [0:6];
  always_ff @(posedge clk_i) begin
    dl_q[0] <= data_i; cn_q[0] <= arg_i.cneg;
    for (int i = 1; i < 7; i++) begin
      dl_q[i] <= dl_q[i-1]; cn_q[i] <= cn_q[i-1];
    end
  end

  logic signed [CoordW-1:0] px, py, pz;
  logic signed [15:0] ax, ay, az;
  assign {px, py, pz, ax, ay, az} = dl_q[6];

  logic signed [15:0] s_s, c_s;
  assign s_s = $signed({1'b0, s_k});
  assign c_s = cn_q[6] ? -$signed({1'b0, c_k}) : $signed({1'b0, c_k});

  // stage 8: axis * sin
  logic signed [31:0] vx_m, vy_m, vz_m;
  assign vx_m = ax * s_s;
  assign vy_m = ay * s_s;
  assign vz_m = az * s_s;
  logic signed [17:0] q0_q, q1_q, q2_q, q3_q;
  logic signed [CoordW-1:0] p1_q, p2_q, p3_q;
  always_ff @(posedge clk_i) begin
    q0_q <= 18'(c_s);
    q1_q <= 18'((vx_m + 32'sd8192) >>> 14);
    q2_q <= 18'((vy_m + 32'sd8192) >>> 14);
    q3_q <= 18'((vz_m + 32'sd8192) >>> 14);
    p1_q <= px; p2_q <= py; p3_q <= pz;
  end

  // stage 9: products of conj(q) with p; products registered, sums next
  // conj q: (q0, -q1, -q2, -q3)
  logic signed [R1W-1:0] m_q [0:11];
  logic signed [17:0] qa0_q, qa1_q, qa2_q, qa3_q;
  always_ff @(posedge clk_i) begin
    m_q[0]  <= R1W'(q1_q * p1_q); m_q[1]  <= R1W'(q2_q * p2_q);
    m_q[2]  <= R1W'(q3_q * p3_q);
    m_q[3]  <= R1W'(q0_q * p1_q); m_q[4]  <= R1W'(q2_q * p3_q);
    m_q[5]  <= R1W'(q3_q * p2_q);
    m_q[6]  <= R1W'(q0_q * p2_q); m_q[7]  <= R1W'(q1_q * p3_q);
    m_q[8]  <= R1W'(q3_q * p1_q);
    m_q[9]  <= R1W'(q0_q * p3_q); m_q[10] <= R1W'(q1_q * p2_q);
    m_q[11] <= R1W'(q2_q * p1_q);
    qa0_q <= q0_q; qa1_q <= q1_q; qa2_q <= q2_q; qa3_q <= q3_q;
  end

  // stage 10: r1 sums
  logic signed [R1W-1:0] r0_q, r1_q, r2_q, r3_q;
  logic signed [17:0] qb0_q, qb1_q, qb2_q, qb3_q;
  always_ff @(posedge clk_i) begin
    r0_q <= m_q[0] + m_q[1] + m_q[2];
    r1_q <= m_q[3] + m_q[4] - m_q[5];
    r2_q <= m_q[6] - m_q[7] + m_q[8];
    r3_q <= m_q[9] + m_q[10] - m_q[11];
    qb0_q <= qa0_q; qb1_q <= qa1_q; qb2_q <= qa2_q; qb3_q <= qa3_q;
  end

  // stage 11: second product terms
  logic signed [R2W-1:0] n_q [0:11];
  always_ff @(posedge clk_i) begin
    n_q[0]  <= R2W'(r0_q * qb1_q); n_q[1]  <= R2W'(r1_q * qb0_q);
    n_q[2]  <= R2W'(r2_q * qb3_q); n_q[3]  <= R2W'(r3_q * qb2_q);
    n_q[4]  <= R2W'(r0_q * qb2_q); n_q[5]  <= R2W'(r1_q * qb3_q);
    n_q[6]  <= R2W'(r2_q * qb0_q); n_q[7]  <= R2W'(r3_q * qb1_q);
    n_q[8]  <= R2W'(r0_q * qb3_q); n_q[9]  <= R2W'(r1_q * qb2_q);
    n_q[10] <= R2W'(r2_q * qb1_q); n_q[11] <= R2W'(r3_q * qb0_q);
  end

  // stage 12 (comb into queue): sums, rounding, saturation
  logic signed [R2W+1:0] t1, t2, t3;
  logic signed [R2W+1:0] hi, lo;
  logic signed [CoordW-1:0] o1, o2, o3;
  logic sat;
  assign hi = (R2W+2)'($signed({1'b0, {(CoordW-1){1'b1}}}));
  assign lo = -hi - 1;
  always_comb begin
    t1 = ((R2W+2)'(n_q[0]) + n_q[1] - n_q[2] + n_q[3] + (R2W+2)'(1 <<< 27)) >>> 28;
    t2 = ((R2W+2)'(n_q[4]) + n_q[5] + n_q[6] - n_q[7] + (R2W+2)'(1 <<< 27)) >>> 28;
    t3 = ((R2W+2)'(n_q[8]) - n_q[9] + n_q[10] + n_q[11] + (R2W+2)'(1 <<< 27)) >>> 28;
    sat = 1'b0;
    if (t1 > hi) begin o1 = hi[CoordW-1:0]; sat = 1'b1; end
    else if (t1 < lo) begin o1 = lo[CoordW-1:0]; sat = 1'b1; end
    else o1 = t1[CoordW-1:0];
    if (t2 > hi) begin o2 = hi[CoordW-1:0]; sat = 1'b1; end
    else if (t2 < lo) begin o2 = lo[CoordW-1:0]; sat = 1'b1; end
    else o2 = t2[CoordW-1:0];
    if (t3 > hi) begin o3 = hi[CoordW-1:0]; sat = 1'b1; end
    else if (t3 < lo) begin o3 = lo[CoordW-1:0]; sat = 1'b1; end
    else o3 = t3[CoordW-1:0];
  end

  // ---- result queue ----
  logic [3*CoordW:0] mem [0:QD-1];
  logic [QA-1:0] wp_q, rp_q;
  logic [QA:0] fill_q;
  logic [3*CoordW:0] head_q;
  logic hv_q;
  logic wr, rd;
  assign wr = v_q[LAT-1];
  assign rd = (fill_q != '0) && (!hv_q || deq);

  always_ff @(posedge clk_i) begin
    if (wr) mem[wp_q] <= {o1, o2, o3, sat};
    if (rd) head_q <= mem[rp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; fill_q <= '0; hv_q <= 1'b0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      fill_q <= fill_q + (QA+1)'(wr) - (QA+1)'(rd);
      if (rd) hv_q <= 1'b1;
      else if (deq) hv_q <= 1'b0;
    end
  end

  assign empty_o = !hv_q;
  assign {rx_o, ry_o, rz_o, sat_o} = head_q;

  `ASSERT_CLK(a_credit, clk_i, rst_ni, cnt_q <= (QA+1)'(QD), "credit overrun")
  `ASSERT_CLK(a_nowrap, clk_i, rst_ni, !(wr && fill_q == (QA+1)'(QD)), "queue overflow")
  `ASSERT_NEXT(a_head, clk_i, rst_ni, rd, hv_q, "head not loaded")

endmodule

// ===== sv/quaternion_axis_angle_rotate_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_axis_angle_rotate_core
// rotates a Q8.16 point about a Q2.14 axis by a binary angle
// ----------------------------------------------------------------------------
// One point per cycle sustained while the result queue has credit. Behind the
// input register an item passes a seven stage sine/cosine polynomial pipeline,
// four stages of quaternion products, the result queue write and the queue read
// register before its result shows on the result ports. A 16-entry result queue
// holds credit for every item in flight, so push keeps going while pop stalls
// until the queue is full.
module quaternion_axis_angle_rotate_core #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [15:0]            axis_x_i,
  input  logic signed [15:0]            axis_y_i,
  input  logic signed [15:0]            axis_z_i,
  input  logic [15:0]                   angle_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [COORD_WIDTH-1:0] rotated_x_o,
  output logic signed [COORD_WIDTH-1:0] rotated_y_o,
  output logic signed [COORD_WIDTH-1:0] rotated_z_o,
  output logic                          saturated_o
);

  logic vld, rdy;
  logic [3*COORD_WIDTH+48-1:0] data;
  qaar_pkg::trig_arg_t arg;

  qaar_front #(.CoordW(COORD_WIDTH)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .px_i(point_x_i), .py_i(point_y_i), .pz_i(point_z_i),
    .ax_i(axis_x_i), .ay_i(axis_y_i), .az_i(axis_z_i), .angle_i,
    .vld_o(vld), .rdy_i(rdy), .data_o(data), .arg_o(arg)
  );

  qaar_back #(.CoordW(COORD_WIDTH)) u_back (
    .clk_i, .rst_ni, .vld_i(vld), .rdy_o(rdy), .data_i(data), .arg_i(arg),
    .empty_o(empty), .pop_i(pop),
    .rx_o(rotated_x_o), .ry_o(rotated_y_o), .rz_o(rotated_z_o), .sat_o(saturated_o)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the quaternion axis-angle rotator against a bit-exact predictor,
// using a directed table followed by random points, axes and angles, with
// random gaps on both queue interfaces and a long pop hold-off
// ----------------------------------------------------------------------------
module tb;

  localparam int CW = 24;
  localparam int NUM_RANDOM = 1750;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD} idle_mode_e;

  typedef struct {
    logic signed [CW-1:0] px, py, pz;
    logic signed [15:0]   ax, ay, az;
    logic [15:0]          ang;
  } rot_in_t;

  typedef struct {
    logic signed [CW-1:0] rx, ry, rz;
    logic                 sat;
  } rot_out_t;

  typedef struct {
    rot_in_t  din;
    bit       typed;
    rot_out_t dout;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [CW-1:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic signed [15:0] axis_x_i = '0, axis_y_i = '0, axis_z_i = '0;
  logic [15:0] angle_i = '0;
  logic signed [CW-1:0] rotated_x_o, rotated_y_o, rotated_z_o;
  logic saturated_o;

  rot_out_t   rotated_q[$];
  stim_row_t  directed[$];
  idle_mode_e idle_mode = IDLE_NONE;
  int         errors = 0;
  int         cycles = 0;
  bit         hold_req = 1'b0;

  quaternion_axis_angle_rotate_core #(.COORD_WIDTH(CW)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .point_x_i(point_x_i), .point_y_i(point_y_i), .point_z_i(point_z_i),
    .axis_x_i(axis_x_i), .axis_y_i(axis_y_i), .axis_z_i(axis_z_i),
    .angle_i(angle_i), .empty(empty), .pop(pop),
    .rotated_x_o(rotated_x_o), .rotated_y_o(rotated_y_o),
    .rotated_z_o(rotated_z_o), .saturated_o(saturated_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // sin(pi/2 * t), t in Q15, result Q14
  function automatic longint sine_q14(int unsigned t);
    longint unsigned x, x2, p;
    x = longint'(t) << 15;
    x2 = (x * x) >> 30;
    p = 64'(qaar_pkg::KC9);
    p = 64'(qaar_pkg::KC7) - ((p * x2) >> 30);
    p = 64'(qaar_pkg::KC5) - ((p * x2) >> 30);
    p = 64'(qaar_pkg::KC3) - ((p * x2) >> 30);
    p = 64'(qaar_pkg::KC1) - ((p * x2) >> 30);
    p = (p * x) >> 30;
    if (p > 64'(qaar_pkg::ONE_Q30)) p = 64'(qaar_pkg::ONE_Q30);
    return longint'((p + 32768) >> 16);
  endfunction

  function automatic longint round_half_up(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clamp_coord(longint v, ref logic sat);
    longint hi, lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic rot_out_t rotate_point(rot_in_t d);
    int unsigned u;
    longint s, c, px, py, pz, a1, a2, a3, w, v1, v2, v3, r1, r2, r3;
    rot_out_t res;
    logic sat;
    u = 32'(d.ang);
    if (u < 32768) begin
      s = sine_q14(u);
      c = sine_q14(32768 - u);
    end else begin
      s = sine_q14(65536 - u);
      c = -sine_q14(u - 32768);
    end
    px = longint'(d.px); py = longint'(d.py); pz = longint'(d.pz);
    a1 = round_half_up(longint'(d.ax) * s, 14);
    a2 = round_half_up(longint'(d.ay) * s, 14);
    a3 = round_half_up(longint'(d.az) * s, 14);
    // p * conj(q), Q30
    w  = a1 * px + a2 * py + a3 * pz;
    v1 = c * px + a2 * pz - a3 * py;
    v2 = c * py - a1 * pz + a3 * px;
    v3 = c * pz + a1 * py - a2 * px;
    // q times that product, vector part, Q44
    r1 = w * a1 + v1 * c - v2 * a3 + v3 * a2;
    r2 = w * a2 + v1 * a3 + v2 * c - v3 * a1;
    r3 = w * a3 - v1 * a2 + v2 * a1 + v3 * c;
    sat = 1'b0;
    res.rx = CW'(clamp_coord(round_half_up(r1, 28), sat));
    res.ry = CW'(clamp_coord(round_half_up(r2, 28), sat));
    res.rz = CW'(clamp_coord(round_half_up(r3, 28), sat));
    res.sat = sat;
    return res;
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic add_row(longint x, longint y, longint z, int ax, int ay, int az, int ang,
                         bit typed, longint ex, longint ey, longint ez, bit esat);
    stim_row_t r;
    r.din = '{CW'(x), CW'(y), CW'(z), 16'(ax), 16'(ay), 16'(az), 16'(ang)};
    r.typed = typed;
    r.dout = '{CW'(ex), CW'(ey), CW'(ez), esat};
    directed.push_back(r);
  endtask

  task automatic send(rot_in_t d, bit typed, rot_out_t exp_out);
    push <= 1'b1;
    point_x_i <= d.px; point_y_i <= d.py; point_z_i <= d.pz;
    axis_x_i <= d.ax; axis_y_i <= d.ay; axis_z_i <= d.az;
    angle_i <= d.ang;
    do @(posedge clk_i); while (full);
    rotated_q.push_back(typed ? exp_out : rotate_point(d));
    if ((idle_mode == IDLE_SEND && chance(55)) || (idle_mode == IDLE_BOTH && chance(17))) begin
      push <= 1'b0;
      do @(posedge clk_i);
      while ((idle_mode == IDLE_SEND && chance(55)) || (idle_mode == IDLE_BOTH && chance(17)));
    end
  endtask

  function automatic rot_in_t random_item();
    rot_in_t d;
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) begin
      // mostly small points with unit axes
      d.px = CW'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      d.py = CW'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      d.pz = CW'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      case ($urandom_range(3))
        0: begin d.ax = 16'sd16384; d.ay = '0; d.az = '0; end
        1: begin d.ax = '0; d.ay = -16'sd16384; d.az = '0; end
        2: begin d.ax = 16'sd9459; d.ay = 16'sd9459; d.az = -16'sd9459; end
        default: begin d.ax = '0; d.ay = 16'sd11585; d.az = 16'sd11585; end
      endcase
    end else begin
      d.px = CW'($urandom); d.py = CW'($urandom); d.pz = CW'($urandom);
      d.ax = 16'($urandom); d.ay = 16'($urandom); d.az = 16'($urandom);
    end
    d.ang = 16'($urandom);
    return d;
  endfunction

  // result checker and pop generator
  always @(posedge clk_i) begin
    rot_out_t e;
    int hold_left;
    if (rst_ni && pop && !empty) begin
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected transaction x=%0d y=%0d z=%0d sat=%0b", $time,
                 rotated_x_o, rotated_y_o, rotated_z_o, saturated_o);
        errors++;
      end else begin
        e = rotated_q.pop_front();
        if (rotated_x_o !== e.rx) begin
          $display("%0t: rotated_x expected %0d actual %0d", $time, e.rx, rotated_x_o);
          errors++;
        end
        if (rotated_y_o !== e.ry) begin
          $display("%0t: rotated_y expected %0d actual %0d", $time, e.ry, rotated_y_o);
          errors++;
        end
        if (rotated_z_o !== e.rz) begin
          $display("%0t: rotated_z expected %0d actual %0d", $time, e.rz, rotated_z_o);
          errors++;
        end
        if (saturated_o !== e.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, e.sat, saturated_o);
          errors++;
        end
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (idle_mode == IDLE_RECV) pop <= !chance(55);
    else if (idle_mode == IDLE_BOTH) pop <= !chance(17);
    else pop <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    rot_out_t none;
    rot_in_t d;
    none = '{'0, '0, '0, 1'b0};
    // zero angle is the identity for any axis
    add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(8388607, -8388608, 1, 16384, 0, 0, 0, 1, 8388607, -8388608, 1, 0);
    add_row(-8388608, 8388607, -1, 32767, -32768, 32767, 0, 1, -8388608, 8388607, -1, 0);
    add_row(65536, 0, 0, -32768, 0, 0, 0, 1, 65536, 0, 0, 0);
    // half turn about a doubled axis scales by four and clamps
    add_row(8388607, 0, 0, -32768, 0, 0, 32768, 1, 8388607, 0, 0, 1);
    add_row(-8388608, 0, 0, -32768, 0, 0, 32768, 1, -8388608, 0, 0, 1);
    add_row(0, 8388607, 0, 0, -32768, 0, 32768, 1, 0, 8388607, 0, 1);
    add_row(0, 0, -8388608, 0, 0, -32768, 32768, 1, 0, 0, -8388608, 1);
    // quadrant boundaries and angle extremes
    add_row(65536, 0, 0, 0, 0, 16384, 16384, 0, 0, 0, 0, 0);
    add_row(65536, 65536, 0, 0, 0, 16384, 32767, 0, 0, 0, 0, 0);
    add_row(65536, 0, 65536, 0, 16384, 0, 32769, 0, 0, 0, 0, 0);
    add_row(0, 65536, 0, 16384, 0, 0, 49152, 0, 0, 0, 0, 0);
    add_row(100, -200, 300, 16384, 0, 0, 65535, 0, 0, 0, 0, 0);
    add_row(100, -200, 300, 0, 16384, 0, 1, 0, 0, 0, 0, 0);
    // non-unit axes, then a unit diagonal axis
    add_row(4000000, -4000000, 4000000, 32767, 32767, 32767, 12345, 0, 0, 0, 0, 0);
    add_row(-1, -1, -1, -32768, -32768, -32768, 40000, 0, 0, 0, 0, 0);
    add_row(123456, 654321, -111111, 5, -7, 3, 20000, 0, 0, 0, 0, 0);
    add_row(8388607, 8388607, 8388607, 9459, 9459, 9459, 21845, 0, 0, 0, 0, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send(directed[i].din, directed[i].typed, directed[i].dout);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      idle_mode = idle_mode_e'((n * 5) / NUM_RANDOM);
      if (n == (NUM_RANDOM * 4) / 5) hold_req = 1'b1;
      d = random_item();
      send(d, 1'b0, none);
    end
    push <= 1'b0;
    idle_mode = IDLE_NONE;

    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && rotated_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/qaar_pkg.sv
sv/qaar_sine.sv
sv/qaar_front.sv
sv/qaar_back.sv
sv/quaternion_axis_angle_rotate_core.sv
verif/tb.sv
